### rtl/multi_channel_echo_pulse_timer_unit_defines.svh
// Assertion macros shared by the echo pulse timer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MULTI_CHANNEL_ECHO_PULSE_TIMER_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_ECHO_PULSE_TIMER_UNIT_DEFINES_SVH

// same-cycle implication
`define EPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ept_pkg.sv
// Types and constants of the echo pulse timer.
// No dependencies; imported by every module of the block.
package ept_pkg;

	localparam int ACT_W  = 5;
	localparam int TMO_W  = 18;
	localparam int DATA_W = 18;
	localparam int ECHO_W = 16;
	localparam int IDX_W  = 4;
	localparam int ST_W   = 2;
	localparam int PULSE_W = 18;

	localparam logic KIND_ARM  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic REG_ACTIVE  = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	localparam logic [ST_W-1:0] ST_VALID     = 2'd0;
	localparam logic [ST_W-1:0] ST_OUT_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_NO_ECHO   = 2'd2;

	localparam logic [TMO_W-1:0]   TIMEOUT_RST   = 18'd69600;
	localparam logic [PULSE_W-1:0] PULSE_MAX     = 18'h3FFFF;
	localparam int                 LATENCY_TICKS = 25;

	typedef struct packed {
		logic             arm;
		logic             push;
		logic [ACT_W-1:0] count;
	} ept_wctl_t;

	typedef struct packed {
		logic             valid;
		logic             rise_seen;
		logic             fall_seen;
		logic [ACT_W-1:0] count;
	} ept_rd_t;

endpackage

### rtl/ept_front.sv
// Front end: accepts arm and tick transfers, samples the echo lanes, ends measurements.
// Depends on ept_pkg; writes the active bank held in ept_queue.
module ept_front import ept_pkg::*; #(
	parameter int LANES     = 16,
	parameter int TIME_BITS = 18
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 kind,
	input  logic [ECHO_W-1:0]    echo_levels,
	input  logic [ACT_W-1:0]     active_sensors,
	input  logic [TMO_W-1:0]     timeout_ticks,
	input  logic                 wr_full,
	input  logic [LANES-1:0]     rise_seen,
	input  logic [LANES-1:0]     fall_seen,
	output logic                 in_stall,
	output ept_wctl_t            wctl,
	output logic [LANES-1:0]     rise_we,
	output logic [LANES-1:0]     fall_we,
	output logic [TIME_BITS-1:0] stamp
);

	localparam int CMP_W = (TIME_BITS > TMO_W) ? TIME_BITS : TMO_W;
	localparam logic [ACT_W-1:0] LANES_C = ACT_W'(LANES);
	localparam logic [CMP_W-1:0] TMAX_X  = CMP_W'({TIME_BITS{1'b1}});

	logic                 measuring_q;
	logic [TIME_BITS-1:0] elapsed_q;
	logic                 accept;
	logic                 tick;
	logic [ACT_W-1:0]     n;
	logic [LANES-1:0]     mask;
	logic [LANES-1:0]     fall_new;
	logic [CMP_W-1:0]     limit_x;
	logic                 done;

	assign in_stall = wr_full;
	assign accept   = in_valid && !wr_full;
	assign tick     = accept && (kind == KIND_TICK) && measuring_q;
	assign stamp    = elapsed_q;
	assign n        = (active_sensors > LANES_C) ? LANES_C : active_sensors;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			mask[i]    = ACT_W'(i) < n;
			fall_we[i] = tick && mask[i] && !echo_levels[i] && rise_seen[i] && !fall_seen[i];
			rise_we[i] = tick && mask[i] && echo_levels[i] && !rise_seen[i] && !fall_we[i];
		end
		fall_new = fall_seen | fall_we;
		limit_x  = (CMP_W'(timeout_ticks) > TMAX_X) ? TMAX_X : CMP_W'(timeout_ticks);
		done     = (&(fall_new | ~mask)) || (CMP_W'(elapsed_q) >= limit_x);
	end

	always_comb begin
		wctl.arm   = accept && (kind == KIND_ARM);
		wctl.push  = tick && done && (n != '0);
		wctl.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measuring_q <= 1'b0;
			elapsed_q   <= '0;
		end else if (wctl.arm) begin
			measuring_q <= 1'b1;
			elapsed_q   <= '0;
		end else if (tick) begin
			if (done) begin
				measuring_q <= 1'b0;
			end else if (elapsed_q != '1) begin
				elapsed_q <= elapsed_q + 1'b1;
			end
		end
	end

endmodule

### rtl/ept_queue.sv
// Two-bank queue of measurement marks between the front end and the result drain.
// Depends on ept_pkg; the front fills one bank while the back drains the other.
module ept_queue import ept_pkg::*; #(
	parameter int LANES     = 16,
	parameter int TIME_BITS = 18,
	parameter int IW        = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ept_wctl_t            wctl,
	input  logic [LANES-1:0]     rise_we,
	input  logic [LANES-1:0]     fall_we,
	input  logic [TIME_BITS-1:0] stamp,
	input  logic [IW-1:0]        rd_idx,
	input  logic                 pop,
	output logic                 wr_full,
	output logic [LANES-1:0]     rise_seen,
	output logic [LANES-1:0]     fall_seen,
	output ept_rd_t              rd,
	output logic [TIME_BITS-1:0] rd_rise_time,
	output logic [TIME_BITS-1:0] rd_fall_time
);

	logic [TIME_BITS-1:0] rise_time_q [2][LANES];
	logic [TIME_BITS-1:0] fall_time_q [2][LANES];
	logic [LANES-1:0]     rise_seen_q [2];
	logic [LANES-1:0]     fall_seen_q [2];
	logic [ACT_W-1:0]     count_q [2];
	logic [1:0]           full_q;
	logic                 wr_q;
	logic                 rd_q;

	assign wr_full   = full_q[wr_q];
	assign rise_seen = rise_seen_q[wr_q];
	assign fall_seen = fall_seen_q[wr_q];

	always_comb begin
		rd.valid     = full_q[rd_q];
		rd.count     = count_q[rd_q];
		rd.rise_seen = rise_seen_q[rd_q][rd_idx];
		rd.fall_seen = fall_seen_q[rd_q][rd_idx];
		rd_rise_time = rise_time_q[rd_q][rd_idx];
		rd_fall_time = fall_time_q[rd_q][rd_idx];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			if (rise_we[i]) begin
				rise_time_q[wr_q][i] <= stamp;
			end
			if (fall_we[i]) begin
				fall_time_q[wr_q][i] <= stamp;
			end
		end
		if (wctl.push) begin
			count_q[wr_q] <= wctl.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_seen_q[0] <= '0;
			rise_seen_q[1] <= '0;
			fall_seen_q[0] <= '0;
			fall_seen_q[1] <= '0;
			full_q         <= '0;
			wr_q           <= 1'b0;
			rd_q           <= 1'b0;
		end else begin
			if (wctl.arm) begin
				rise_seen_q[wr_q] <= '0;
				fall_seen_q[wr_q] <= '0;
			end else begin
				rise_seen_q[wr_q] <= rise_seen_q[wr_q] | rise_we;
				fall_seen_q[wr_q] <= fall_seen_q[wr_q] | fall_we;
			end
			full_q <= (full_q | ({1'b0, wctl.push} << wr_q)) & ~({1'b0, pop} << rd_q);
			if (wctl.push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
		end
	end

endmodule

### rtl/ept_back.sv
// Back end: walks the channels of a finished bank and drives the result register.
// Depends on ept_pkg; reads ept_queue one channel per transfer.
module ept_back import ept_pkg::*; #(
	parameter int TIME_BITS = 18,
	parameter int IW        = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ept_rd_t              rd,
	input  logic [TIME_BITS-1:0] rd_rise_time,
	input  logic [TIME_BITS-1:0] rd_fall_time,
	input  logic                 out_stall,
	output logic [IW-1:0]        rd_idx,
	output logic                 pop,
	output logic                 out_valid,
	output logic [IDX_W-1:0]     sensor_index,
	output logic [ST_W-1:0]      status,
	output logic [PULSE_W-1:0]   pulse_ticks,
	output logic                 last
);

	localparam int CMP_W = (TIME_BITS > PULSE_W) ? TIME_BITS : PULSE_W;
	localparam logic [TIME_BITS-1:0] LAT_C  = TIME_BITS'(LATENCY_TICKS);
	localparam logic [CMP_W-1:0]     PMAX_X = CMP_W'(PULSE_MAX);

	logic [IW-1:0]        idx_q;
	logic                 out_valid_q;
	logic                 load;
	logic                 is_last;
	logic [TIME_BITS-1:0] diff;
	logic [TIME_BITS-1:0] width;
	logic [PULSE_W-1:0]   width_c;
	logic [ST_W-1:0]      status_c;

	assign rd_idx    = idx_q;
	assign out_valid = out_valid_q;
	assign load      = rd.valid && (!out_valid_q || !out_stall);
	assign is_last   = (ACT_W'(idx_q) + ACT_W'(1)) == rd.count;
	assign pop       = load && is_last;

	always_comb begin
		diff  = rd_fall_time - rd_rise_time;
		width = (diff > LAT_C) ? diff - LAT_C : '0;
		priority if (!rd.rise_seen) begin
			status_c = ST_NO_ECHO;
			width_c  = '0;
		end else if (!rd.fall_seen) begin
			status_c = ST_OUT_RANGE;
			width_c  = '0;
		end else begin
			status_c = ST_VALID;
			width_c  = (CMP_W'(width) > PMAX_X) ? PULSE_MAX : PULSE_W'(width);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sensor_index <= IDX_W'(idx_q);
			status       <= status_c;
			pulse_ticks  <= width_c;
			last         <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? '0 : idx_q + 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/multi_channel_echo_pulse_timer_unit.sv
// Multi-channel ultrasonic echo pulse timer, top level.
// Input: kind (arm or tick) with echo_levels; output: one result per active channel.
// Config: cfg_we/cfg_index/cfg_data write active_sensors (0) and timeout_ticks (1).
// A tick or arm transfer is taken every cycle; the front end stalls only when both
// result banks still hold undelivered results.
// A measurement ends on the tick where all active channels have fallen or the stamp
// reaches timeout_ticks; its results pass the bank's full flag and then the output register,
// one result per cycle while out_stall is low, channel 0 first, last set on the final one.
// Results are held in an output register; while out_stall is high it holds and the
// drain waits, and the front keeps sampling into the other bank.
// Reset clears the marks and full flags of both banks, the measuring flag and the
// registers (active_sensors 0, timeout_ticks 69600); ticks are ignored until an arm.
`include "multi_channel_echo_pulse_timer_unit_defines.svh"
module multi_channel_echo_pulse_timer_unit import ept_pkg::*; #(
	parameter int MAX_SENSORS = 16,
	parameter int TIME_BITS   = 18
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [DATA_W-1:0]   cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic [ECHO_W-1:0]   echo_levels,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [IDX_W-1:0]    sensor_index,
	output logic [ST_W-1:0]     status,
	output logic [PULSE_W-1:0]  pulse_ticks,
	output logic                last
);

	localparam int LANES = (MAX_SENSORS < ECHO_W) ? MAX_SENSORS : ECHO_W;
	localparam int IW    = (LANES > 1) ? $clog2(LANES) : 1;

	logic [ACT_W-1:0]     active_q;
	logic [TMO_W-1:0]     timeout_q;
	ept_wctl_t            wctl;
	ept_rd_t              rd;
	logic [LANES-1:0]     rise_we;
	logic [LANES-1:0]     fall_we;
	logic [LANES-1:0]     rise_seen;
	logic [LANES-1:0]     fall_seen;
	logic [TIME_BITS-1:0] stamp;
	logic                 wr_full;
	logic [IW-1:0]        rd_idx;
	logic                 pop;
	logic [TIME_BITS-1:0] rd_rise_time;
	logic [TIME_BITS-1:0] rd_fall_time;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACTIVE:  active_q  <= cfg_data[ACT_W-1:0];
				REG_TIMEOUT: timeout_q <= cfg_data[TMO_W-1:0];
				default:     ;
			endcase
		end
	end

	ept_front #(.LANES(LANES), .TIME_BITS(TIME_BITS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.kind           (kind),
		.echo_levels    (echo_levels),
		.active_sensors (active_q),
		.timeout_ticks  (timeout_q),
		.wr_full        (wr_full),
		.rise_seen      (rise_seen),
		.fall_seen      (fall_seen),
		.in_stall       (in_stall),
		.wctl           (wctl),
		.rise_we        (rise_we),
		.fall_we        (fall_we),
		.stamp          (stamp)
	);

	ept_queue #(.LANES(LANES), .TIME_BITS(TIME_BITS), .IW(IW)) u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.wctl         (wctl),
		.rise_we      (rise_we),
		.fall_we      (fall_we),
		.stamp        (stamp),
		.rd_idx       (rd_idx),
		.pop          (pop),
		.wr_full      (wr_full),
		.rise_seen    (rise_seen),
		.fall_seen    (fall_seen),
		.rd           (rd),
		.rd_rise_time (rd_rise_time),
		.rd_fall_time (rd_fall_time)
	);

	ept_back #(.TIME_BITS(TIME_BITS), .IW(IW)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd           (rd),
		.rd_rise_time (rd_rise_time),
		.rd_fall_time (rd_fall_time),
		.out_stall    (out_stall),
		.rd_idx       (rd_idx),
		.pop          (pop),
		.out_valid    (out_valid),
		.sensor_index (sensor_index),
		.status       (status),
		.pulse_ticks  (pulse_ticks),
		.last         (last)
	);

	`EPT_ASSERT_IMP(a_stall_has_result, clk, arst_n, in_stall, out_valid, "front stalled with no pending result")
	`EPT_ASSERT_NXT(a_index_advance, clk, arst_n, out_valid && !out_stall && !last, out_valid && (sensor_index == $past(sensor_index) + 4'd1), "result channel did not advance")
	`EPT_ASSERT_IMP(a_index_range, clk, arst_n, out_valid, ACT_W'(sensor_index) < ACT_W'(LANES), "result channel out of range")

endmodule

### dv/tb_multi_channel_echo_pulse_timer_unit.sv
// Self-checking testbench for the multi-channel echo pulse timer top level.
// Holds its own model of the channel marks and elapsed-tick counter and checks each result.
// Depends on ept_pkg and multi_channel_echo_pulse_timer_unit only.
module tb_multi_channel_echo_pulse_timer_unit;
	import ept_pkg::*;

	localparam int CHANNELS      = 16;
	localparam int SETTLE_CYCLES = 4;
	localparam int QUIET_LIMIT   = 2000;

	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic [ST_W-1:0]    st;
		logic [PULSE_W-1:0] width;
		logic               last;
	} echo_result_t;

	typedef enum int {PULSE_CLEAN, PULSE_SILENT, PULSE_STUCK, PULSE_NOISY} chan_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_index = REG_ACTIVE;
	logic [DATA_W-1:0]  cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               kind = KIND_ARM;
	logic [ECHO_W-1:0]  echo_levels = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [IDX_W-1:0]   sensor_index;
	logic [ST_W-1:0]    status;
	logic [PULSE_W-1:0] pulse_ticks;
	logic               last;

	multi_channel_echo_pulse_timer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.echo_levels(echo_levels),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sensor_index(sensor_index),
		.status(status),
		.pulse_ticks(pulse_ticks),
		.last(last)
	);

	// echo timing state
	logic [TMO_W-1:0]    rise_stamp [CHANNELS];
	logic [TMO_W-1:0]    fall_stamp [CHANNELS];
	logic [CHANNELS-1:0] rose = '0;
	logic [CHANNELS-1:0] fell = '0;
	logic [TMO_W-1:0]    tick_count = '0;
	logic                armed = 1'b0;
	logic [ACT_W-1:0]    active_cfg = '0;
	logic [TMO_W-1:0]    timeout_cfg = TIMEOUT_RST;

	echo_result_t expected_echoes [$];
	echo_result_t want;
	int mismatches = 0;
	int quiet_cycles = 0;
	int send_gap_pct = 8;
	int recv_stall_pct = 69;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task time_echo_transfer(input logic k, input logic [ECHO_W-1:0] lv);
		int n;
		logic [TMO_W-1:0] stamp;
		logic [TMO_W-1:0] span;
		logic [CHANNELS-1:0] used;
		echo_result_t r;
		n = (active_cfg > CHANNELS) ? CHANNELS : active_cfg;
		if (k == KIND_ARM) begin
			for (int i = 0; i < CHANNELS; i++) begin
				rise_stamp[i] = '0;
				fall_stamp[i] = '0;
			end
			rose = '0;
			fell = '0;
			tick_count = '0;
			armed = 1'b1;
			return;
		end
		if (!armed)
			return;
		stamp = tick_count;
		for (int i = 0; i < n; i++) begin
			if (!lv[i] && rose[i] && !fell[i]) begin
				fall_stamp[i] = stamp;
				fell[i] = 1'b1;
			end else if (lv[i] && !rose[i]) begin
				rise_stamp[i] = stamp;
				rose[i] = 1'b1;
			end
		end
		used = (n == CHANNELS) ? '1 : ((CHANNELS'(1) << n) - CHANNELS'(1));
		if ((fell & used) != used && stamp < timeout_cfg) begin
			if (stamp != '1)
				tick_count = stamp + 1'b1;
			return;
		end
		armed = 1'b0;
		for (int i = 0; i < n; i++) begin
			r.idx = IDX_W'(i);
			r.width = '0;
			if (rose[i]) begin
				if (fell[i]) begin
					span = fall_stamp[i] - rise_stamp[i];
					r.st = ST_VALID;
					r.width = (span > LATENCY_TICKS) ? span - TMO_W'(LATENCY_TICKS) : '0;
				end else begin
					r.st = ST_OUT_RANGE;
				end
			end else begin
				r.st = ST_NO_ECHO;
			end
			r.last = (i == n - 1);
			expected_echoes.push_back(r);
		end
	endtask

	task note_mismatch(input string what, input int want_v, input int got_v);
		if (mismatches < 10)
			$display("mismatch on %s: expected %0d, actual %0d", what, want_v, got_v);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_echoes.size() == 0) begin
					note_mismatch("unexpected result, sensor_index", -1, sensor_index);
				end else begin
					want = expected_echoes.pop_front();
					if (sensor_index != want.idx)
						note_mismatch("sensor_index", want.idx, sensor_index);
					if (status != want.st)
						note_mismatch("status", want.st, status);
					if (pulse_ticks != want.width)
						note_mismatch("pulse_ticks", want.width, pulse_ticks);
					if (last != want.last)
						note_mismatch("last", want.last, last);
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_ACTIVE)
					active_cfg = cfg_data[ACT_W-1:0];
				else
					timeout_cfg = cfg_data[TMO_W-1:0];
			end
			if (in_valid && !in_stall)
				time_echo_transfer(kind, echo_levels);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("multi_channel_echo_pulse_timer_unit regression: fail");
				$finish;
			end
		end
	end

	task send_transfer(input logic k, input logic [ECHO_W-1:0] lv);
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		echo_levels <= lv;
		do @(posedge clk); while (in_stall);
	endtask

	task drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_echoes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task load_config(input logic [ACT_W-1:0] act, input logic [TMO_W-1:0] tmo);
		logic [DATA_W-1:0] word;
		word = DATA_W'($urandom);
		word[ACT_W-1:0] = act;
		cfg_we <= 1'b1;
		cfg_index <= REG_ACTIVE;
		cfg_data <= word;
		@(posedge clk);
		cfg_index <= REG_TIMEOUT;
		cfg_data <= tmo;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task test_idle_ticks_and_zero_channels();
		send_transfer(KIND_TICK, 16'hFFFF);
		send_transfer(KIND_ARM, 16'h0000);
		send_transfer(KIND_TICK, 16'h0000);
		send_transfer(KIND_TICK, 16'hA5A5);
		drain_results();
	endtask

	task test_channel_clamp_and_zero_timeout();
		load_config(5'd31, '0);
		send_transfer(KIND_ARM, 16'h0000);
		send_transfer(KIND_TICK, 16'hFFFF);
		send_transfer(KIND_ARM, 16'hFFFF);
		send_transfer(KIND_TICK, 16'h0F0F);
		drain_results();
	endtask

	task test_restart_and_short_pulses();
		load_config(5'd3, 18'd3);
		send_transfer(KIND_ARM, 16'h0000);
		send_transfer(KIND_TICK, 16'h0003);
		send_transfer(KIND_ARM, 16'h0000);
		send_transfer(KIND_TICK, 16'hFFF3);
		send_transfer(KIND_TICK, 16'hFFF1);
		send_transfer(KIND_TICK, 16'hFFF0);
		send_transfer(KIND_TICK, 16'h0000);
		drain_results();
	endtask

	task test_full_range_timeout();
		load_config(5'd2, '1);
		send_transfer(KIND_ARM, 16'h0000);
		send_transfer(KIND_TICK, 16'h0003);
		send_transfer(KIND_TICK, 16'h0002);
		send_transfer(KIND_TICK, 16'h0000);
		drain_results();
	endtask

	task test_random_echoes(input int gap_pct, input int stall_pct, input int item_goal,
			input int act_hi);
		int sent;
		int n;
		int pick;
		int longest;
		int limit_ticks;
		int cut_at;
		int t;
		int rise_at [CHANNELS];
		int width_of [CHANNELS];
		chan_mode_t mode_of [CHANNELS];
		logic [ECHO_W-1:0] lv;
		logic [ACT_W-1:0] act;
		logic [TMO_W-1:0] tmo;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		act = '0;
		tmo = '0;
		while (sent < item_goal) begin
			if (sent == 0 || $urandom_range(99) < 30) begin
				drain_results();
				act = ACT_W'($urandom_range(act_hi, 0));
				tmo = TMO_W'($urandom_range(80, 20));
				load_config(act, tmo);
			end
			n = (act > CHANNELS) ? CHANNELS : act;
			longest = 0;
			for (int i = 0; i < CHANNELS; i++) begin
				rise_at[i] = $urandom_range(15);
				width_of[i] = $urandom_range(45, 1);
				pick = $urandom_range(9);
				if (pick < 6)
					mode_of[i] = PULSE_CLEAN;
				else if (pick == 6)
					mode_of[i] = PULSE_SILENT;
				else if (pick == 7)
					mode_of[i] = PULSE_STUCK;
				else
					mode_of[i] = PULSE_NOISY;
				if (i < n) begin
					if (mode_of[i] != PULSE_CLEAN)
						longest = tmo;
					else if (rise_at[i] + width_of[i] > longest)
						longest = rise_at[i] + width_of[i];
				end
			end
			limit_ticks = ((longest < tmo) ? longest : tmo) + 1;
			cut_at = ($urandom_range(9) == 0) ? $urandom_range(limit_ticks - 1) : -1;
			send_transfer(KIND_ARM, ECHO_W'($urandom));
			sent++;
			t = 0;
			while (t < limit_ticks) begin
				if (t == cut_at) begin
					send_transfer(KIND_ARM, ECHO_W'($urandom));
					sent++;
					cut_at = -1;
					t = 0;
				end
				for (int i = 0; i < CHANNELS; i++) begin
					if (i >= n)
						lv[i] = 1'($urandom_range(1));
					else
						case (mode_of[i])
							PULSE_CLEAN: lv[i] = (t >= rise_at[i] && t < rise_at[i] + width_of[i]);
							PULSE_SILENT: lv[i] = 1'b0;
							PULSE_STUCK: lv[i] = (t >= rise_at[i]);
							default: lv[i] = 1'($urandom_range(1));
						endcase
				end
				send_transfer(KIND_TICK, lv);
				sent++;
				t++;
			end
		end
		drain_results();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ticks_and_zero_channels();
		test_channel_clamp_and_zero_timeout();
		test_restart_and_short_pulses();
		test_full_range_timeout();
		test_random_echoes(8, 69, 50, 16);
		test_random_echoes(69, 8, 50, 16);
		test_random_echoes(0, 0, 50, 31);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_echoes.size() == 0)
			$display("multi_channel_echo_pulse_timer_unit regression: pass");
		else
			$display("multi_channel_echo_pulse_timer_unit regression: fail");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/ept_pkg.sv
rtl/ept_front.sv
rtl/ept_queue.sv
rtl/ept_back.sv
rtl/multi_channel_echo_pulse_timer_unit.sv
dv/tb_multi_channel_echo_pulse_timer_unit.sv
